### rtl/rfrm_pkg.sv
// rfrm_pkg: shared widths, constants and divider handshake types for the
// rolling frame-rate meter. No dependencies.
package rfrm_pkg;

  // field widths
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned IDEAL_W = 30;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned FPS_W   = 10;
  localparam int unsigned BIT_W   = $clog2(FPS_W);

  // default window length
  localparam int unsigned WINDOW_DEF = 16;

  // arithmetic constants
  localparam longint unsigned NS_PER_SECOND = 64'd1000000000;
  localparam logic [IDEAL_W-1:0] IDEAL_RESET = IDEAL_W'(16666666);
  localparam logic [FPS_W-1:0] FPS_MAX = FPS_W'(999);

  // request to the divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] divisor;
  } div_req_t;

  // answer from the divider
  typedef struct packed {
    logic             done;
    logic [FPS_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/rolling_frame_rate_meter_core.sv
// Rolling frame-rate meter: keeps the last WINDOW frame durations in a ring
// memory with a running sum, and reports frames per second over the window.
// Uses rfrm_pkg and rfrm_div.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one measured frame time in
//   ns per item. Output channel (out_valid_o/out_ready_i) returns one item:
//   min(999, WINDOW*1e9 / sum) and the updated window sum.
//   cfg_we_i with ideal_frame_ns_i sets the ideal frame time and refills the
//   window with it; the write is taken only while the block is idle.
// Sequence:
//   One item at a time. After accept, the calc state does the ring
//   read-modify-write; the divider then runs a range check and resolves one
//   quotient bit per cycle over 10 bits, and stops after the range check when
//   the sum is zero or the rate saturates. The result then moves to the output
//   register. A new item is accepted only once the previous one has left the core.
// Reset:
//   The window reads as the reset ideal frame time in every slot; per-slot
//   valid bits stand in for the fill, so no clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next item is still
//   accepted and computed, and holds in the core until the register is free.
module rolling_frame_rate_meter_core import rfrm_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FRAME_W-1:0] frame_time_ns_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FPS_W-1:0]   frames_per_second_o,
  output logic [SUM_W-1:0]   window_sum_ns_o,
  input  logic               cfg_we_i,
  input  logic [IDEAL_W-1:0] ideal_frame_ns_i
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SUM_W-1:0] WIN_MUL  = SUM_W'(WINDOW);
  localparam logic [SUM_W-1:0] DIVIDEND = SUM_W'(64'(WINDOW) * NS_PER_SECOND);
  localparam logic [SUM_W-1:0] SUM_RESET =
      SUM_W'(64'(WINDOW) * 64'(IDEAL_RESET));
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_PUSH
  } core_state_e;

  core_state_e          state_q;
  logic [IDEAL_W-1:0]   ideal_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W-1:0]     sum_d;
  logic [SLOT_W-1:0]    slot_q;
  logic [WINDOW-1:0]    valid_q;
  logic [FRAME_W-1:0]   frame_q;
  logic [FRAME_W-1:0]   rd_data_q;
  logic [FRAME_W-1:0]   old_val;
  logic                 out_valid_q;
  logic [FPS_W-1:0]     fps_q;
  logic [SUM_W-1:0]     sum_out_q;
  logic                 in_accept;
  logic                 out_free;

  // ring of frame durations
  logic [FRAME_W-1:0]   ring_mem [WINDOW];

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // slot never written since reset or refill reads as the ideal time
  assign old_val = valid_q[slot_q] ? rd_data_q : FRAME_W'(ideal_q);
  assign sum_d   = sum_q - SUM_W'(old_val) + SUM_W'(frame_q);

  // memory port: read on accept, write back in the calc cycle; consecutive
  // items use different slots, so a read never meets a pending write
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_data_q <= ring_mem[slot_q];
      frame_q   <= frame_time_ns_i;
    end
    if (state_q == S_CALC) begin
      ring_mem[slot_q] <= frame_q;
    end
  end

  // window state, sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ideal_q     <= IDEAL_RESET;
      sum_q       <= SUM_RESET;
      slot_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      fps_q       <= '0;
      sum_out_q   <= '0;
    end else begin
      // output valid: set when a finished item moves out, cleared on handshake
      if ((state_q == S_PUSH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          // register write refills the window
          if (cfg_we_i) begin
            ideal_q <= ideal_frame_ns_i;
            sum_q   <= SUM_W'(WIN_MUL * SUM_W'(ideal_frame_ns_i));
            slot_q  <= '0;
            valid_q <= '0;
          end
          if (in_accept) begin
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          sum_q           <= sum_d;
          valid_q[slot_q] <= 1'b1;
          slot_q          <= (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
          state_q         <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            fps_q       <= div_rsp.quotient;
            sum_out_q   <= sum_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // divider gets the updated sum
  assign div_req.start   = (state_q == S_CALC);
  assign div_req.divisor = sum_d;

  rfrm_div #(
    .Dividend(DIVIDEND)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign out_valid_o         = out_valid_q;
  assign frames_per_second_o = fps_q;
  assign window_sum_ns_o     = sum_out_q;

`ifndef SYNTH
  // divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

  // reported rate never exceeds the saturation value
  a_fps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frames_per_second_o <= FPS_MAX))
    else $error("frame rate above saturation");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("second item accepted while busy");
`endif

endmodule

### rtl/rfrm_div.sv
// rfrm_div: iterative restoring divider of a fixed dividend by the window sum,
// one quotient bit per cycle, saturating at the maximum rate. Uses rfrm_pkg.
module rfrm_div import rfrm_pkg::*; #(
  parameter logic [SUM_W-1:0] Dividend = SUM_W'(64'(WINDOW_DEF) * NS_PER_SECOND)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned SH_W = SUM_W + FPS_W - 1;

  typedef enum logic [1:0] {
    D_IDLE,
    D_CHECK,
    D_ITER
  } div_state_e;

  div_state_e           state_q;
  logic [SUM_W-1:0]     div_q;
  logic [SUM_W-1:0]     rem_q;
  logic [SH_W-1:0]      dshift_q;
  logic [BIT_W-1:0]     bit_q;
  logic [FPS_W-1:0]     quot_q;
  logic                 done_q;

  logic                 big_quot;
  logic                 ge;
  logic [FPS_W-1:0]     quot_d;

  // quotient would need more than FPS_W bits, or divisor is zero
  assign big_quot = (div_q == '0) ||
                    ({div_q, {FPS_W{1'b0}}} <= (SUM_W + FPS_W)'(rem_q));

  // one restoring step
  assign ge     = (SH_W'(rem_q) >= dshift_q);
  assign quot_d = ge ? (quot_q | (FPS_W'(1) << bit_q)) : quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= D_IDLE;
      done_q   <= 1'b0;
      quot_q   <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      dshift_q <= '0;
      bit_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            div_q   <= req_i.divisor;
            rem_q   <= Dividend;
            state_q <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (big_quot) begin
            quot_q  <= FPS_MAX;
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end else begin
            quot_q   <= '0;
            dshift_q <= {div_q, {(FPS_W - 1){1'b0}}};
            bit_q    <= BIT_W'(FPS_W - 1);
            state_q  <= D_ITER;
          end
        end
        D_ITER: begin
          if (ge) begin
            rem_q <= rem_q - dshift_q[SUM_W-1:0];
          end
          quot_q   <= quot_d;
          dshift_q <= dshift_q >> 1;
          bit_q    <= bit_q - BIT_W'(1);
          if (bit_q == '0) begin
            done_q  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  // clamp quotients between the maximum and the next power of two
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quot_q > FPS_MAX) ? FPS_MAX : quot_q;

endmodule

### test/rolling_frame_rate_meter_core_tb.sv
// Testbench for rolling_frame_rate_meter_core: drives directed and random frame times and
// ideal frame time writes, and checks every rate and window sum item.
// Depends on rfrm_pkg and the meter RTL only.
module rolling_frame_rate_meter_core_tb;
  import rfrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW = WINDOW_DEF;
  localparam logic [IDEAL_W-1:0] IDEAL_LOW = IDEAL_W'(4166666);
  localparam logic [IDEAL_W-1:0] IDEAL_HIGH = IDEAL_W'(1000000000);
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 117;

  // one expected result item
  typedef struct {
    logic [FPS_W-1:0] fps;
    logic [SUM_W-1:0] sum;
  } rate_result_t;

  // window predictor and store of expected rates
  class rate_scoreboard;
    logic [FRAME_W-1:0] duration_ring[WINDOW];
    int unsigned        oldest;
    logic [SUM_W-1:0]   window_sum;
    rate_result_t       expected_rates[$];
    int unsigned        errors;

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // a register write fills every slot with the ideal frame time
    function void refill(input logic [IDEAL_W-1:0] ideal);
      for (int i = 0; i < WINDOW; i++) duration_ring[i] = FRAME_W'(ideal);
      oldest = 0;
      window_sum = SUM_W'(64'(WINDOW) * 64'(ideal));
    endfunction

    // accepted frame time: retire oldest slot, work out the rate
    function void note_frame(input logic [FRAME_W-1:0] dur_ns);
      rate_result_t    r;
      longint unsigned quotient;
      window_sum = window_sum - SUM_W'(duration_ring[oldest]) + SUM_W'(dur_ns);
      duration_ring[oldest] = dur_ns;
      oldest = (oldest + 1) % WINDOW;
      if (window_sum == '0) begin
        r.fps = FPS_MAX;
      end else begin
        quotient = (64'(WINDOW) * NS_PER_SECOND) / 64'(window_sum);
        r.fps = (quotient > 64'(FPS_MAX)) ? FPS_MAX : FPS_W'(quotient);
      end
      r.sum = window_sum;
      expected_rates.push_back(r);
    endfunction

    task check_result(input logic [FPS_W-1:0] fps, input logic [SUM_W-1:0] sum);
      rate_result_t r;
      if (expected_rates.size() == 0) begin
        report_mismatch($sformatf("unexpected item fps=%0d sum=%0d", fps, sum));
      end else begin
        r = expected_rates.pop_front();
        if (fps !== r.fps)
          report_mismatch($sformatf("fps %0d, want %0d", fps, r.fps));
        if (sum !== r.sum)
          report_mismatch($sformatf("window sum %0d, want %0d", sum, r.sum));
      end
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [FRAME_W-1:0] frame_time_ns_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [FPS_W-1:0]   frames_per_second_o;
  logic [SUM_W-1:0]   window_sum_ns_o;
  logic               cfg_we_i;
  logic [IDEAL_W-1:0] ideal_frame_ns_i;

  rate_scoreboard board = new();
  logic [IDEAL_W-1:0] ideal_now;
  int unsigned        stall_mode;
  int unsigned        stall_left;
  bit                 sender_burst;

  rolling_frame_rate_meter_core #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .frame_time_ns_i    (frame_time_ns_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .frames_per_second_o(frames_per_second_o),
    .window_sum_ns_o    (window_sum_ns_o),
    .cfg_we_i           (cfg_we_i),
    .ideal_frame_ns_i   (ideal_frame_ns_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // output side: check accepted items, then pick the next ready level
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      board.check_result(frames_per_second_o, window_sum_ns_o);
    if (stall_mode == 0) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:79]:  out_ready_i <= 1'b1;
        [80:94]: begin
          stall_left = $urandom_range(0, 2);
          out_ready_i <= 1'b0;
        end
        default: begin
          stall_left = (stall_mode == 2) ? $urandom_range(10, 50) : $urandom_range(3, 8);
          out_ready_i <= 1'b0;
        end
      endcase
    end
  end

  // gap before the next input item: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random frame time, often around the ideal one
  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return FRAME_W'(ideal_now - ideal_now / 8 + $urandom_range(0, ideal_now / 4));
    if (r < 65) return FRAME_W'($urandom);
    if (r < 75) return FRAME_W'($urandom_range(0, 1000));
    if (r < 80) return '0;
    if (r < 85) return '1;
    return FRAME_W'($urandom_range(4166666, 100000000));
  endfunction

  task send_frame(input logic [FRAME_W-1:0] dur_ns);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    frame_time_ns_i <= dur_ns;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_frame(dur_ns);
  endtask

  task wait_drained();
    in_valid_i <= 1'b0;
    while (board.expected_rates.size() != 0) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task write_ideal(input logic [IDEAL_W-1:0] ideal);
    cfg_we_i         <= 1'b1;
    ideal_frame_ns_i <= ideal;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ideal_now = ideal;
    board.refill(ideal);
  endtask

  task send_list(input logic [FRAME_W-1:0] frames[$]);
    foreach (frames[i]) send_frame(frames[i]);
    wait_drained();
  endtask

  // main sequence
  initial begin
    logic [IDEAL_W-1:0] ideal;
    in_valid_i       = 1'b0;
    frame_time_ns_i  = '0;
    out_ready_i      = 1'b0;
    cfg_we_i         = 1'b0;
    ideal_frame_ns_i = '0;
    stall_mode       = 1;
    stall_left       = 0;
    sender_burst     = 1'b0;
    ideal_now        = IDEAL_RESET;
    board.errors     = 0;
    board.refill(IDEAL_RESET);
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: window as it comes out of reset, field extremes
    send_list('{32'hFFFF_FFFF, 32'h0, 32'h1, 32'd16666666, 32'h8000_0000,
                32'h7FFF_FFFF, 32'd4166666, 32'd33333333});
    // zero ideal gives a zero sum, then a tiny sum that saturates
    write_ideal('0);
    send_list('{32'h0, 32'h0, 32'h1, 32'h0});
    // largest register value and largest frames: rate near zero
    write_ideal('1);
    send_list('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0});
    write_ideal(IDEAL_LOW);
    send_list('{32'd4166666, 32'd1000});
    write_ideal(IDEAL_HIGH);
    send_list('{32'd1000000000});

    // random phases, each with its own ideal frame time and idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       ideal = IDEAL_W'($urandom_range(4166666, 1000000000));
        1:       ideal = IDEAL_LOW;
        2:       ideal = IDEAL_HIGH;
        default: ideal = IDEAL_W'($urandom);
      endcase
      write_ideal(ideal);
      stall_mode   = p % 3;
      sender_burst = (p == 2 || p == 5);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off mid-phase until every pending rate is back
        if (p == 1 && i == 60) wait_drained();
        send_frame(pick_frame());
      end
      wait_drained();
    end

    repeat (30) @(posedge clk_i);
    if (board.expected_rates.size() != 0)
      board.report_mismatch($sformatf("%0d items never came", board.expected_rates.size()));
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
